// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scancode key buffer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside of reset.
`define SKB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SKB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SKB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/skb_pkg.sv -----
// ---------------------------------------------------------------------------
// Scancode key buffer package
// Sizes, command and status types and the set 1 ASCII lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package skb_pkg;

	// Ring geometry.
	localparam int RING_DEPTH = 1024;
	localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	// Field widths.
	localparam int CODE_W = 8;
	localparam int KEY_W  = 7;
	localparam int CHAR_W = 7;

	// Operation codes of a request.
	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // a request is taken this cycle
		logic is_read;  // the request reads the ring
		logic ring_rd;  // the read finds data and pops the ring
	} skb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ring_empty;
	} skb_sts_t;

	// Set 1 make code to ASCII; codes without a character map to zero.
	function automatic logic [CHAR_W-1:0] ascii_lut(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] ch;
		case (key)
			7'd1:    ch = 7'h1B;
			7'd2:    ch = 7'h31;
			7'd3:    ch = 7'h32;
			7'd4:    ch = 7'h33;
			7'd5:    ch = 7'h34;
			7'd6:    ch = 7'h35;
			7'd7:    ch = 7'h36;
			7'd8:    ch = 7'h37;
			7'd9:    ch = 7'h38;
			7'd10:   ch = 7'h39;
			7'd11:   ch = 7'h30;
			7'd12:   ch = 7'h2D;
			7'd13:   ch = 7'h3D;
			7'd14:   ch = 7'h08;
			7'd15:   ch = 7'h09;
			7'd16:   ch = 7'h71;
			7'd17:   ch = 7'h77;
			7'd18:   ch = 7'h65;
			7'd19:   ch = 7'h72;
			7'd20:   ch = 7'h74;
			7'd21:   ch = 7'h79;
			7'd22:   ch = 7'h75;
			7'd23:   ch = 7'h69;
			7'd24:   ch = 7'h6F;
			7'd25:   ch = 7'h70;
			7'd26:   ch = 7'h5B;
			7'd27:   ch = 7'h5D;
			7'd28:   ch = 7'h0A;
			7'd30:   ch = 7'h61;
			7'd31:   ch = 7'h73;
			7'd32:   ch = 7'h64;
			7'd33:   ch = 7'h66;
			7'd34:   ch = 7'h67;
			7'd35:   ch = 7'h68;
			7'd36:   ch = 7'h6A;
			7'd37:   ch = 7'h6B;
			7'd38:   ch = 7'h6C;
			7'd39:   ch = 7'h3B;
			7'd40:   ch = 7'h27;
			7'd41:   ch = 7'h60;
			7'd43:   ch = 7'h5C;
			7'd44:   ch = 7'h7A;
			7'd45:   ch = 7'h78;
			7'd46:   ch = 7'h63;
			7'd47:   ch = 7'h76;
			7'd48:   ch = 7'h62;
			7'd49:   ch = 7'h6E;
			7'd50:   ch = 7'h6D;
			7'd51:   ch = 7'h2C;
			7'd52:   ch = 7'h2E;
			7'd53:   ch = 7'h2F;
			7'd55:   ch = 7'h2A;
			7'd57:   ch = 7'h20;
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/skb_in_if.sv -----
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one scancode event or ring read request.
// ---------------------------------------------------------------------------
`default_nettype none

interface skb_in_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [skb_pkg::CODE_W-1:0]   scancode;
	logic [skb_pkg::KEY_W-1:0]    key_index;

	modport source (output valid, output op, output scancode, output key_index, input ready);
	modport sink   (input valid, input op, input scancode, input key_index, output ready);
endinterface

`default_nettype wire

// ----- hdl/skb_out_if.sv -----
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the result of one request.
// ---------------------------------------------------------------------------
`default_nettype none

interface skb_out_if;
	logic                         valid;
	logic                         ready;
	logic                         echo_valid;
	logic [skb_pkg::CHAR_W-1:0]   echo_ascii;
	logic [skb_pkg::KEY_W-1:0]    read_data;
	logic                         read_empty;
	logic                         key_down;

	modport source (output valid, output echo_valid, output echo_ascii, output read_data,
		output read_empty, output key_down, input ready);
	modport sink   (input valid, input echo_valid, input echo_ascii, input read_data,
		input read_empty, input key_down, output ready);
endinterface

`default_nettype wire

// ----- hdl/skb_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module skb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/skb_ctrl.sv -----
// ---------------------------------------------------------------------------
// Scancode key buffer controller
// Tracks the result register and issues commands to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module skb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_op,
	output      logic              in_ready,
	output      logic              out_valid,
	input  wire logic              out_ready,
	input  wire skb_pkg::skb_sts_t sts,
	output      skb_pkg::skb_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_FULL = 2'b10
	} skb_state_t;

	skb_state_t state_q;
	skb_state_t state_d;
	logic       take;

	// A request is taken when the result register is empty or is emptied now.
	assign in_ready  = (state_q == ST_IDLE) || out_ready;
	assign out_valid = (state_q == ST_FULL);
	assign take      = in_valid && in_ready;

	// Commands to the datapath.
	always_comb begin
		cmd.accept  = take;
		cmd.is_read = (in_op == skb_pkg::OP_READ);
		cmd.ring_rd = take && (in_op == skb_pkg::OP_READ) && !sts.ring_empty;
	end

	// Next state.
	always_comb begin
		case (state_q)
			ST_IDLE: state_d = take ? ST_FULL : ST_IDLE;
			ST_FULL: state_d = (out_ready && !take) ? ST_IDLE : ST_FULL;
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SKB_ASSERT(a_take_gives_result, clk, arst_n, take |=> out_valid, "accepted request lost its result")
	`SKB_ASSERT(a_pop_needs_take, clk, arst_n, cmd.ring_rd |-> (cmd.accept && cmd.is_read), "ring pop without read request")
	`SKB_ASSERT_ALWAYS(a_no_overwrite, clk, !(in_ready && out_valid && !out_ready), "request taken over a held result")

endmodule

`default_nettype wire

// ----- hdl/skb_dp.sv -----
// ---------------------------------------------------------------------------
// Scancode key buffer datapath
// Ring pointers, ring memory, pressed key map and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module skb_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire skb_pkg::skb_cmd_t            cmd,
	output      skb_pkg::skb_sts_t            sts,
	input  wire logic [skb_pkg::CODE_W-1:0]   scancode,
	input  wire logic [skb_pkg::KEY_W-1:0]    key_index,
	output      logic                         echo_valid,
	output      logic [skb_pkg::CHAR_W-1:0]   echo_ascii,
	output      logic [skb_pkg::KEY_W-1:0]    read_data,
	output      logic                         read_empty,
	output      logic                         key_down
);

	localparam logic [skb_pkg::RING_AW-1:0] PTR_LAST = skb_pkg::RING_AW'(skb_pkg::RING_DEPTH - 1);
	localparam logic [skb_pkg::RING_AW-1:0] PTR_ONE  = skb_pkg::RING_AW'(1);

	logic [skb_pkg::RING_AW-1:0] wp_q;
	logic [skb_pkg::RING_AW-1:0] rp_q;
	logic [(1 << skb_pkg::KEY_W)-1:0] map_q;
	logic [(1 << skb_pkg::KEY_W)-1:0] map_d;
	logic [skb_pkg::KEY_W-1:0]   key;
	logic                        brk;
	logic                        make;
	logic [skb_pkg::KEY_W-1:0]   ram_rdata;

	logic                        echo_valid_q;
	logic [skb_pkg::CHAR_W-1:0]  echo_ascii_q;
	logic                        rd_hit_q;
	logic                        rd_empty_q;
	logic                        key_down_q;

	// Decode of an event request.
	assign key  = scancode[skb_pkg::KEY_W-1:0];
	assign brk  = scancode[skb_pkg::CODE_W-1];
	assign make = cmd.accept && !cmd.is_read && !brk;

	assign sts.ring_empty = (wp_q == rp_q);

	// Ring pointers wrap at the ring depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (make) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_ONE;
			end
			if (cmd.ring_rd) begin
				rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + PTR_ONE;
			end
		end
	end

	// Make codes are stored; the read port pops the oldest one.
	skb_ram #(
		.WIDTH (skb_pkg::KEY_W),
		.DEPTH (skb_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (make),
		.waddr (wp_q),
		.wdata (key),
		.re    (cmd.ring_rd),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	// Pressed map: a make code sets the key's bit, a break code clears it.
	always_comb begin
		map_d = map_q;
		if (cmd.accept && !cmd.is_read) begin
			map_d[key] = !brk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0;
		end else begin
			map_q <= map_d;
		end
	end

	// Result register, loaded with each taken request.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			echo_valid_q <= make;
			echo_ascii_q <= make ? skb_pkg::ascii_lut(key) : '0;
			rd_hit_q     <= cmd.ring_rd;
			rd_empty_q   <= cmd.is_read && sts.ring_empty;
			key_down_q   <= map_d[key_index];
		end
	end

	assign echo_valid = echo_valid_q;
	assign echo_ascii = echo_ascii_q;
	assign read_data  = rd_hit_q ? ram_rdata : '0;
	assign read_empty = rd_empty_q;
	assign key_down   = key_down_q;

	`SKB_ASSERT(a_break_keeps_wp, clk, arst_n, (cmd.accept && !cmd.is_read && brk) |=> $stable(wp_q), "break code moved the write pointer")
	`SKB_ASSERT(a_pop_not_empty, clk, arst_n, cmd.ring_rd |-> !sts.ring_empty, "ring popped while empty")

endmodule

`default_nettype wire

// ----- hdl/scancode_key_buffer_core.sv -----
// ---------------------------------------------------------------------------
// Scancode key buffer core
// Set 1 keyboard front end: make-code ring buffer, pressed key map and echo.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request: op selects a scancode event or a ring read,
//   scancode is the raw set 1 byte and key_index picks the key whose pressed
//   state is reported. out_ch returns exactly one result per request.
//   A make code is stored in the ring, sets its pressed bit and is echoed as
//   ASCII; a break code only clears its pressed bit. A read pops the oldest
//   stored code or flags an empty ring. The ring never reports full: writes
//   overwrite, and a write that catches the read pointer empties the ring.
//   The result is registered and valid in the cycle after the request is taken.
//   Throughput: one request per cycle while out_ch.ready stays high; the
//   single result register and the one ring access per request set this.
//   When the receiver stalls, the result holds and in_ch.ready follows
//   out_ch.ready, so at most one result waits.
//   Reset clears both ring pointers, the pressed map and the result valid;
//   ring contents are not cleared and there is no startup sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module scancode_key_buffer_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skb_in_if.sink     in_ch,
	skb_out_if.source  out_ch
);

	skb_pkg::skb_cmd_t cmd;
	skb_pkg::skb_sts_t sts;

	// Handshake and sequencing.
	skb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and result formation.
	skb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.scancode   (in_ch.scancode),
		.key_index  (in_ch.key_index),
		.echo_valid (out_ch.echo_valid),
		.echo_ascii (out_ch.echo_ascii),
		.read_data  (out_ch.read_data),
		.read_empty (out_ch.read_empty),
		.key_down   (out_ch.key_down)
	);

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ---------------------------------------------------------------------------
// Scancode key buffer testbench
// Drives scancode events and ring read requests into the core and compares
// every result with a shadow copy of the ring, its pointers and the pressed
// key map. The run covers directed corner cases, random typing with idling
// on both sides, a long receiver stall and a full ring overrun.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_CYCLES  = 300;

	typedef logic [skb_pkg::CODE_W-1:0] code_t;
	typedef logic [skb_pkg::KEY_W-1:0]  key_t;
	typedef logic [7:0]                 field_t;

	localparam code_t BREAK_FLAG = 8'h80;

	// Set 1 make code to character; codes past the last row have none.
	localparam int CHAR_ROWS = 58;
	localparam logic [0:CHAR_ROWS-1][7:0] SET1_CHARS = {
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20
	};

	typedef struct packed {
		logic                       echo_valid;
		logic [skb_pkg::CHAR_W-1:0] echo_ascii;
		key_t                       read_data;
		logic                       read_empty;
		logic                       key_down;
	} key_result_t;

	logic clk;
	logic arst_n;

	skb_in_if  req_if ();
	skb_out_if rsp_if ();

	scancode_key_buffer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_if),
		.out_ch (rsp_if)
	);

	// Shadow state of the block.
	key_t             ring_shadow [skb_pkg::RING_DEPTH];
	int               wr_ptr    = 0;
	int               rd_ptr    = 0;
	logic [127:0]     keys_held = '0;

	key_result_t      expected_results [$];

	int               send_idle_pct = 0;
	int               recv_idle_pct = 0;
	int               hold_cycles   = 0;
	int               error_count   = 0;
	int               cycle_count   = 0;
	key_t             last_key      = '0;

	// Clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [skb_pkg::CHAR_W-1:0] set1_char(input key_t key);
		return (key < CHAR_ROWS) ? SET1_CHARS[key][skb_pkg::CHAR_W-1:0] : '0;
	endfunction

	function automatic int ring_fill();
		return (wr_ptr - rd_ptr + skb_pkg::RING_DEPTH) % skb_pkg::RING_DEPTH;
	endfunction

	// Apply one request to the shadow state and return the result it causes.
	function automatic key_result_t apply_request(input logic op, input code_t code,
		input key_t key);
		key_result_t r;
		key_t        k;
		r = '0;
		k = code[skb_pkg::KEY_W-1:0];
		if (op == skb_pkg::OP_EVENT) begin
			if ((code & BREAK_FLAG) != 0) begin
				keys_held[k] = 1'b0;
			end else begin
				ring_shadow[wr_ptr] = k;
				wr_ptr = (wr_ptr + 1) % skb_pkg::RING_DEPTH;
				keys_held[k] = 1'b1;
				r.echo_valid = 1'b1;
				r.echo_ascii = set1_char(k);
			end
		end else if (wr_ptr == rd_ptr) begin
			r.read_empty = 1'b1;
		end else begin
			r.read_data = ring_shadow[rd_ptr];
			rd_ptr = (rd_ptr + 1) % skb_pkg::RING_DEPTH;
		end
		r.key_down = keys_held[key];
		return r;
	endfunction

	// Every mismatch is printed on one line and counted.
	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input field_t got, input field_t want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	// Random make code, biased toward keys that carry a character.
	function automatic code_t make_code();
		key_t k;
		if ($urandom_range(0, 99) < 70) begin
			k = key_t'($urandom_range(0, CHAR_ROWS - 1));
		end else begin
			k = key_t'($urandom_range(0, 127));
		end
		return {1'b0, k};
	endfunction

	// Key to report: often the last one typed, so that key_down is seen set.
	function automatic key_t report_key();
		key_t k;
		k = key_t'($urandom_range(0, 127));
		return ($urandom_range(0, 1) == 1) ? last_key : k;
	endfunction

	function automatic code_t any_code();
		return code_t'($urandom_range(0, 255));
	endfunction

	function automatic key_t any_key();
		return key_t'($urandom_range(0, 127));
	endfunction

	// Offer one request, wait for it to be taken, then record its result.
	// Called and returns just after a falling edge.
	task automatic send_request(input logic op, input code_t code, input key_t key);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid     = 1'b1;
		req_if.op        = op;
		req_if.scancode  = code;
		req_if.key_index = key;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		expected_results.push_back(apply_request(op, code, key));
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		req_if.valid = 1'b0;
		while (expected_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Corner cases: empty reads, field extremes, unmapped codes and breaks.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_request(skb_pkg::OP_READ, 8'h00, 7'h00);
		send_request(skb_pkg::OP_READ, 8'hFF, 7'h7F);
		send_request(skb_pkg::OP_EVENT, 8'h00, 7'h00);
		send_request(skb_pkg::OP_EVENT, 8'h01, 7'h01);
		send_request(skb_pkg::OP_EVENT, 8'h0E, 7'h0E);
		send_request(skb_pkg::OP_EVENT, 8'h39, 7'h00);
		send_request(skb_pkg::OP_EVENT, 8'h3A, 7'h3A);
		send_request(skb_pkg::OP_EVENT, 8'h1D, 7'h39);
		send_request(skb_pkg::OP_EVENT, 8'h7F, 7'h7F);
		send_request(skb_pkg::OP_EVENT, 8'h80, 7'h00);
		send_request(skb_pkg::OP_EVENT, 8'hFF, 7'h7F);
		send_request(skb_pkg::OP_EVENT, 8'h81, 7'h0E);
		// Releasing a key that is not held changes nothing.
		send_request(skb_pkg::OP_EVENT, 8'hAA, 7'h2A);
		repeat (7) begin
			send_request(skb_pkg::OP_READ, 8'h55, 7'h01);
		end
		send_request(skb_pkg::OP_READ, 8'hFF, 7'h39);
	endtask

	// Random typing: make and break codes, reads and some raw noise.
	task automatic test_mixed_typing(input int count, input int send_pct, input int recv_pct);
		int    pick;
		code_t code;
		key_t  k;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_request(skb_pkg::OP_READ, any_code(), report_key());
			end else if (pick < 70) begin
				code = make_code();
				last_key = code[skb_pkg::KEY_W-1:0];
				send_request(skb_pkg::OP_EVENT, code, report_key());
			end else if (pick < 95) begin
				k = ($urandom_range(0, 99) < 70) ? last_key : report_key();
				send_request(skb_pkg::OP_EVENT, BREAK_FLAG | {1'b0, k}, report_key());
			end else begin
				send_request(skb_pkg::OP_EVENT, any_code(), any_key());
			end
		end
	endtask

	// The receiver holds off while requests keep coming, so the input stalls.
	task automatic test_receiver_stall();
		code_t code;
		send_idle_pct = 0;
		hold_cycles = STALL_CYCLES;
		repeat (60) begin
			code = make_code();
			last_key = code[skb_pkg::KEY_W-1:0];
			send_request(skb_pkg::OP_EVENT, code, report_key());
		end
		wait_for_results();
	endtask

	// Fill the ring to one short of full, then let the write pointer lap the
	// read pointer so that the pending codes are lost and the ring is empty.
	task automatic test_ring_overrun();
		while (ring_fill() != 0) begin
			send_request(skb_pkg::OP_READ, any_code(), report_key());
		end
		repeat (skb_pkg::RING_DEPTH - 1) begin
			send_request(skb_pkg::OP_EVENT, make_code(), any_key());
		end
		repeat (2) begin
			send_request(skb_pkg::OP_READ, any_code(), report_key());
		end
		repeat (3) begin
			send_request(skb_pkg::OP_EVENT, make_code(), any_key());
		end
		send_request(skb_pkg::OP_READ, any_code(), report_key());
		repeat (5) begin
			send_request(skb_pkg::OP_EVENT, make_code(), any_key());
		end
		repeat (6) begin
			send_request(skb_pkg::OP_READ, any_code(), report_key());
		end
	endtask

	// Result ready, with random idling and the long hold-off.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_if.ready = 1'b0;
				hold_cycles--;
			end else begin
				rsp_if.ready = ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Compare each result taken with the oldest expectation.
	always @(posedge clk) begin
		key_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result arrived with no request outstanding");
			end else begin
				want = expected_results.pop_front();
				check_field("echo_valid", field_t'(rsp_if.echo_valid),
					field_t'(want.echo_valid));
				check_field("echo_ascii", field_t'(rsp_if.echo_ascii),
					field_t'(want.echo_ascii));
				check_field("read_data", field_t'(rsp_if.read_data),
					field_t'(want.read_data));
				check_field("read_empty", field_t'(rsp_if.read_empty),
					field_t'(want.read_empty));
				check_field("key_down", field_t'(rsp_if.key_down),
					field_t'(want.key_down));
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("FAILURE");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.op        = skb_pkg::OP_EVENT;
		req_if.scancode  = '0;
		req_if.key_index = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_mixed_typing(50, 22, 78);
		test_receiver_stall();
		test_mixed_typing(50, 78, 22);
		test_ring_overrun();
		test_mixed_typing(50, 0, 0);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch("results still outstanding at the end");
		end
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/skb_pkg.sv
hdl/skb_in_if.sv
hdl/skb_out_if.sv
hdl/skb_ram.sv
hdl/skb_ctrl.sv
hdl/skb_dp.sv
hdl/scancode_key_buffer_core.sv
test/tb_top.sv
